/* design/population_std_deviation_macros.svh */
// ----------------------------------------------------------------------------
// population_std_deviation_macros
// assertion macros shared by the standard deviation block
// ----------------------------------------------------------------------------
`ifndef POPULATION_STD_DEVIATION_MACROS_SVH
`define POPULATION_STD_DEVIATION_MACROS_SVH

`ifndef SYNTHESIS
// checked property, off while reset is asserted
`define PSD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// checked property, active during reset too
`define PSD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PSD_ASSERT(name, clk, rst_n, prop, msg)
`define PSD_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

/* design/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// widths, job record and sequencer states of the standard deviation block
// ----------------------------------------------------------------------------
package psd_pkg;

    // longest run that is accumulated
    localparam int unsigned MAX_COUNT = 4096;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned STD_W    = 23;
    localparam int unsigned FRAC_W   = 16;

    localparam int unsigned LOG_N   = $clog2(MAX_COUNT);
    localparam int unsigned CNT_W   = $clog2(MAX_COUNT + 1);
    localparam int unsigned SUM_W   = SAMPLE_W + LOG_N + 1;
    localparam int unsigned SQS_W   = 2 * SAMPLE_W - 1;
    localparam int unsigned SQ_W    = SQS_W + LOG_N;
    localparam int unsigned MAG_W   = SUM_W - 1;

    // n * S2 in two halves
    localparam int unsigned SQ_LO_W = (SQ_W + 1) / 2;
    localparam int unsigned SQ_HI_W = SQ_W - SQ_LO_W;
    localparam int unsigned PLO_W   = CNT_W + SQ_LO_W;
    localparam int unsigned PHI_W   = CNT_W + SQ_HI_W;
    localparam int unsigned NPR_W   = CNT_W + SQ_W;
    localparam int unsigned MSQ_W   = 2 * MAG_W;
    localparam int unsigned DIFF_W  = (NPR_W > MSQ_W) ? NPR_W : MSQ_W;

    // scaled divide by n*n, then square root
    localparam int unsigned NSQ_W   = 2 * CNT_W;
    localparam int unsigned DVD_W   = DIFF_W + FRAC_W;
    localparam int unsigned ROOT_W  = STD_W + 1;
    localparam int unsigned RAD_W   = 2 * ROOT_W;
    localparam int unsigned SREM_W  = ROOT_W + 1;
    localparam int unsigned DSTEP_W = $clog2(DVD_W);
    localparam int unsigned RSTEP_W = $clog2(ROOT_W);
    localparam int unsigned STEP_W  = (DSTEP_W > RSTEP_W) ? DSTEP_W : RSTEP_W;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // snapshot of one finished run
    typedef struct packed {
        logic                    ovf;
        logic [CNT_W-1:0]        cnt;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SQR,
        ST_SUB,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } back_state_t;

endpackage

/* design/psd_front.sv */
// ----------------------------------------------------------------------------
// psd_front
// accumulates count, sum and sum of squares, hands off a job at end of run
// ----------------------------------------------------------------------------
`include "population_std_deviation_macros.svh"

module psd_front (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [psd_pkg::SAMPLE_W-1:0]     s_sample,
    input  logic                                    s_last,
    input  logic                                    queue_ready,
    output logic                                    push_valid,
    output psd_pkg::job_t                           push_job
);

    logic [psd_pkg::CNT_W-1:0]        cnt_reg, cnt_next, cnt_acc;
    logic signed [psd_pkg::SUM_W-1:0] sum_reg, sum_next, sum_acc;
    logic [psd_pkg::SQ_W-1:0]         sq_reg, sq_next, sq_acc;
    logic                             too_many_reg, too_many_next, ovf_acc;
    logic signed [2*psd_pkg::SAMPLE_W-1:0] prod;
    logic                             take;
    logic                             room;

    always_comb begin
        take    = s_valid && queue_ready;
        room    = cnt_reg < psd_pkg::CNT_W'(psd_pkg::MAX_COUNT);
        prod    = s_sample * s_sample;
        cnt_acc = room ? cnt_reg + psd_pkg::CNT_W'(1) : cnt_reg;
        sum_acc = room ? sum_reg + psd_pkg::SUM_W'(s_sample) : sum_reg;
        sq_acc  = room ? sq_reg + psd_pkg::SQ_W'(prod[psd_pkg::SQS_W-1:0]) : sq_reg;
        ovf_acc = too_many_reg | ~room;

        push_valid   = take && s_last;
        push_job.ovf = ovf_acc;
        push_job.cnt = cnt_acc;
        push_job.sum = sum_acc;
        push_job.sq  = sq_acc;

        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        too_many_next = too_many_reg;
        if (take) begin
            if (s_last) begin
                cnt_next      = '0;
                sum_next      = '0;
                sq_next       = '0;
                too_many_next = 1'b0;
            end else begin
                cnt_next      = cnt_acc;
                sum_next      = sum_acc;
                sq_next       = sq_acc;
                too_many_next = ovf_acc;
            end
        end
    end

    assign s_ready = queue_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            too_many_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            sq_reg       <= sq_next;
            too_many_reg <= too_many_next;
        end
    end

    `PSD_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= psd_pkg::CNT_W'(psd_pkg::MAX_COUNT), "sample count beyond limit")

endmodule

/* design/psd_fifo.sv */
// ----------------------------------------------------------------------------
// psd_fifo
// short job queue between accumulator and arithmetic sequencer
// ----------------------------------------------------------------------------
`include "population_std_deviation_macros.svh"

module psd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    input  psd_pkg::job_t push_job,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output psd_pkg::job_t pop_job
);

    psd_pkg::job_t              slot_reg [psd_pkg::QUEUE_DEPTH];
    logic [psd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [psd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [psd_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push;

    always_comb begin
        push_ready  = count_reg != psd_pkg::QCNT_W'(psd_pkg::QUEUE_DEPTH);
        pop_valid   = count_reg != '0;
        pop_job     = slot_reg[rd_ptr_reg];
        do_push     = push_valid && push_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == psd_pkg::QPTR_W'(psd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + psd_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == psd_pkg::QPTR_W'(psd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + psd_pkg::QPTR_W'(1);
        end
        count_next = count_reg + psd_pkg::QCNT_W'(do_push) - psd_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `PSD_ASSERT(a_pop_nonempty, aclk, aresetn, pop |-> (count_reg != '0), "pop from empty queue")
    `PSD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= psd_pkg::QCNT_W'(psd_pkg::QUEUE_DEPTH), "queue count beyond depth")

endmodule

/* design/psd_back.sv */
// ----------------------------------------------------------------------------
// psd_back
// sequencer: variance numerator, scaled radix-2 divide, bit-pair square root
// ----------------------------------------------------------------------------
`include "population_std_deviation_macros.svh"

module psd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    input  psd_pkg::job_t                 job,
    output logic                          job_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [psd_pkg::STD_W-1:0]     m_std_dev,
    output logic                          m_overflow
);

    psd_pkg::back_state_t state_reg, state_next;

    logic [psd_pkg::CNT_W-1:0]  cnt_reg;
    logic [psd_pkg::MAG_W-1:0]  mag_reg;
    logic [psd_pkg::SQ_W-1:0]   sq_reg;
    logic                       ovf_reg;
    logic                       zero_reg;
    logic [psd_pkg::PLO_W-1:0]  prod_lo_reg;
    logic [psd_pkg::PHI_W-1:0]  prod_hi_reg;
    logic [psd_pkg::NPR_W-1:0]  nprod_reg;
    logic [psd_pkg::MSQ_W-1:0]  magsq_reg;
    logic [psd_pkg::NSQ_W-1:0]  nsq_reg;
    logic [psd_pkg::DVD_W-1:0]  dvd_reg;
    logic [psd_pkg::NSQ_W-1:0]  rem_reg;
    logic [psd_pkg::SREM_W-1:0] srem_reg;
    logic [psd_pkg::ROOT_W-1:0] root_reg;
    logic [psd_pkg::STEP_W-1:0] step_reg;
    logic                       out_valid_reg;
    logic [psd_pkg::STD_W-1:0]  out_std_reg;
    logic                       out_ovf_reg;

    logic                        load_out;
    logic                        last_step;
    logic signed [psd_pkg::SUM_W-1:0] sum_abs;
    logic [psd_pkg::NSQ_W:0]     dtrial;
    logic                        dge;
    logic [psd_pkg::SREM_W+1:0]  strial_rem;
    logic [psd_pkg::SREM_W+1:0]  strial;
    logic                        sge;

    // next state and handshake
    always_comb begin
        state_next = state_reg;
        job_pop    = 1'b0;
        load_out   = 1'b0;
        last_step  = step_reg == '0;
        unique case (state_reg)
            psd_pkg::ST_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    state_next = psd_pkg::ST_MUL_LO;
                end
            end
            psd_pkg::ST_MUL_LO: state_next = psd_pkg::ST_MUL_HI;
            psd_pkg::ST_MUL_HI: state_next = psd_pkg::ST_SQR;
            psd_pkg::ST_SQR:    state_next = psd_pkg::ST_SUB;
            psd_pkg::ST_SUB:    state_next = psd_pkg::ST_DIV;
            psd_pkg::ST_DIV: begin
                if (last_step) begin
                    state_next = psd_pkg::ST_SQRT;
                end
            end
            psd_pkg::ST_SQRT: begin
                if (last_step) begin
                    state_next = psd_pkg::ST_DONE;
                end
            end
            psd_pkg::ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = psd_pkg::ST_IDLE;
                end
            end
            default: state_next = psd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // one divide step and one square root step
    always_comb begin
        sum_abs    = (job.sum < 0) ? -job.sum : job.sum;
        dtrial     = {rem_reg, dvd_reg[psd_pkg::DVD_W-1]};
        dge        = dtrial >= {1'b0, nsq_reg};
        strial_rem = {srem_reg, dvd_reg[psd_pkg::RAD_W-1 -: 2]};
        strial     = {1'b0, root_reg, 2'b01};
        sge        = strial_rem >= strial;
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            psd_pkg::ST_IDLE: begin
                if (job_valid) begin
                    cnt_reg  <= job.cnt;
                    mag_reg  <= sum_abs[psd_pkg::MAG_W-1:0];
                    sq_reg   <= job.sq;
                    ovf_reg  <= job.ovf;
                    zero_reg <= job.cnt == '0;
                end
            end
            psd_pkg::ST_MUL_LO: begin
                prod_lo_reg <= psd_pkg::PLO_W'(cnt_reg) *
                               psd_pkg::PLO_W'(sq_reg[psd_pkg::SQ_LO_W-1:0]);
            end
            psd_pkg::ST_MUL_HI: begin
                prod_hi_reg <= psd_pkg::PHI_W'(cnt_reg) *
                               psd_pkg::PHI_W'(sq_reg[psd_pkg::SQ_W-1:psd_pkg::SQ_LO_W]);
            end
            psd_pkg::ST_SQR: begin
                magsq_reg <= psd_pkg::MSQ_W'(mag_reg) * psd_pkg::MSQ_W'(mag_reg);
                nprod_reg <= {prod_hi_reg, psd_pkg::SQ_LO_W'(0)} +
                             psd_pkg::NPR_W'(prod_lo_reg);
            end
            psd_pkg::ST_SUB: begin
                dvd_reg  <= {psd_pkg::DIFF_W'(nprod_reg) - psd_pkg::DIFF_W'(magsq_reg),
                             psd_pkg::FRAC_W'(0)};
                nsq_reg  <= psd_pkg::NSQ_W'(cnt_reg) * psd_pkg::NSQ_W'(cnt_reg);
                rem_reg  <= '0;
                step_reg <= psd_pkg::STEP_W'(psd_pkg::DVD_W - 1);
            end
            psd_pkg::ST_DIV: begin
                rem_reg <= dge ? psd_pkg::NSQ_W'(dtrial - {1'b0, nsq_reg})
                               : dtrial[psd_pkg::NSQ_W-1:0];
                dvd_reg <= {dvd_reg[psd_pkg::DVD_W-2:0], dge};
                if (last_step) begin
                    step_reg <= psd_pkg::STEP_W'(psd_pkg::ROOT_W - 1);
                    srem_reg <= '0;
                    root_reg <= '0;
                end else begin
                    step_reg <= step_reg - psd_pkg::STEP_W'(1);
                end
            end
            psd_pkg::ST_SQRT: begin
                srem_reg <= sge ? psd_pkg::SREM_W'(strial_rem - strial)
                                : psd_pkg::SREM_W'(strial_rem);
                root_reg <= {root_reg[psd_pkg::ROOT_W-2:0], sge};
                dvd_reg  <= {dvd_reg[psd_pkg::DVD_W-3:0], 2'b00};
                step_reg <= step_reg - psd_pkg::STEP_W'(1);
            end
            psd_pkg::ST_DONE: begin
                if (load_out) begin
                    out_std_reg <= zero_reg ? '0 : root_reg[psd_pkg::STD_W-1:0];
                    out_ovf_reg <= ovf_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_std_dev  = out_std_reg;
    assign m_overflow = out_ovf_reg;

    `PSD_ASSERT(a_div_rem_bound, aclk, aresetn, (state_reg == psd_pkg::ST_DIV && nsq_reg != '0) |-> (rem_reg < nsq_reg), "divide remainder not below divisor")
    `PSD_ASSERT(a_done_holds, aclk, aresetn, (state_reg == psd_pkg::ST_DONE && out_valid_reg && !m_ready) |=> (state_reg == psd_pkg::ST_DONE), "result overwritten before taken")

endmodule

/* design/population_std_deviation.sv */
// ----------------------------------------------------------------------------
// population_std_deviation
// streaming population standard deviation of signed 16-bit samples
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  s_        in    s_valid/s_ready    s_sample[15:0] signed, s_last
//  m_        out   m_valid/m_ready    m_std_dev[22:0] (8 fraction bits), m_overflow
//
//  one sample per cycle while s_ready is high; the item with s_last snapshots
//  the run into a two-entry job queue and the accumulators clear for the next run
//  each job holds the sequencer from taking it through the product and subtraction
//  states, 72 divide steps and 24 square root steps to loading the result
//  reset is synchronous and active low; result data registers carry no reset
//  s_ready drops only while the job queue is full; a result waiting on
//  m_ready holds the next job in the sequencer's final state
//
`include "population_std_deviation_macros.svh"

module population_std_deviation (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [psd_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_last,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [psd_pkg::STD_W-1:0]           m_std_dev,
    output logic                                m_overflow
);

    // front to queue
    logic          push_valid;
    logic          push_ready;
    psd_pkg::job_t push_job;

    // queue to sequencer
    logic          job_valid;
    logic          job_pop;
    psd_pkg::job_t job;

    // accumulator: count, sum and sum of squares per run
    psd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_last      (s_last),
        .queue_ready (push_ready),
        .push_valid  (push_valid),
        .push_job    (push_job)
    );

    // finished runs wait here while the sequencer is busy
    psd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (job_pop),
        .pop_valid  (job_valid),
        .pop_job    (job)
    );

    // n*S2 - S1^2, scaled divide by n^2, square root, output register
    psd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (job_valid),
        .job        (job),
        .job_pop    (job_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_std_dev  (m_std_dev),
        .m_overflow (m_overflow)
    );

    // a run end is only taken when the queue has room for it
    `PSD_ASSERT(a_push_room, aclk, aresetn, push_valid |-> push_ready, "run end taken with queue full")

endmodule

/* tb/population_std_deviation_tb.sv */
// ----------------------------------------------------------------------------
// population_std_deviation_tb
// streams runs of signed samples through the standard deviation block and
// checks every result against an exact integer prediction of the run's
// population standard deviation and overflow flag
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module population_std_deviation_tb;

    // long receiver hold-off, in cycles
    localparam int HOLD_LEN      = 600;
    // cycles allowed for a spurious late result at the end
    localparam int TAIL_CYCLES   = 300;
    // fewest items per random phase
    localparam int PHASE_ITEMS   = 300;

    typedef struct {
        logic signed [psd_pkg::SAMPLE_W-1:0] sample;
        logic                                last;
    } sample_item_t;

    typedef struct {
        logic [psd_pkg::STD_W-1:0] std_dev;
        logic                      overflow;
    } run_result_t;

    // sample run styles
    typedef enum int {
        RUN_RANDOM,
        RUN_EXTREMES,
        RUN_CONSTANT,
        RUN_CLUSTER
    } run_style_t;

    logic                                aclk       = 1'b0;
    logic                                aresetn    = 1'b0;
    logic                                s_valid    = 1'b0;
    logic                                s_ready;
    logic signed [psd_pkg::SAMPLE_W-1:0] s_sample   = '0;
    logic                                s_last     = 1'b0;
    logic                                m_valid;
    logic                                m_ready    = 1'b0;
    logic [psd_pkg::STD_W-1:0]           m_std_dev;
    logic                                m_overflow;

    // items waiting to be offered, and results still owed by the block
    sample_item_t pending_items[$];
    run_result_t  std_expected[$];

    int items_queued  = 0;
    int items_taken   = 0;
    int error_count   = 0;

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long hold-off requests from the stimulus, served by the receiver
    int hold_tickets   = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    // the offered item was accepted at the last rising edge
    logic taken = 1'b0;

    // running accumulators of the predicted run
    longint unsigned run_count   = 0;
    longint signed   run_sum     = 0;
    longint unsigned run_sq_sum  = 0;
    logic            run_dropped = 1'b0;

    population_std_deviation u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_std_dev  (m_std_dev),
        .m_overflow (m_overflow)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // floor(sqrt(floor((n*S2 - S1^2) * 65536 / n^2))), 8 fraction bits
    function automatic logic [psd_pkg::STD_W-1:0] deviation_q8(longint unsigned n,
                                                               longint signed s1,
                                                               longint unsigned s2);
        logic [127:0] n_w;
        logic [127:0] mag;
        logic [127:0] spread;
        logic [127:0] scaled;
        logic [127:0] root;
        logic [127:0] trial;
        if (n == 0) begin
            return '0;
        end
        n_w    = 128'(n);
        mag    = (s1 < 0) ? 128'(-s1) : 128'(s1);
        spread = n_w * 128'(s2) - mag * mag;
        scaled = (spread << 16) / (n_w * n_w);
        // bit-by-bit integer square root, the radicand stays well below 2^64
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= scaled) begin
                root = trial;
            end
        end
        return root[psd_pkg::STD_W-1:0];
    endfunction

    // fold one accepted item into the run, and on the last item owe a result
    task automatic absorb_sample(logic signed [psd_pkg::SAMPLE_W-1:0] sample, logic last);
        longint signed s;
        run_result_t   res;
        s = longint'(sample);
        if (run_count < psd_pkg::MAX_COUNT) begin
            run_count  = run_count + 1;
            run_sum    = run_sum + s;
            run_sq_sum = run_sq_sum + longint'(s * s);
        end else begin
            // run too long: the item is dropped, even when it carries last
            run_dropped = 1'b1;
        end
        if (last) begin
            res.std_dev  = deviation_q8(run_count, run_sum, run_sq_sum);
            res.overflow = run_dropped;
            std_expected.push_back(res);
            run_count   = 0;
            run_sum     = 0;
            run_sq_sum  = 0;
            run_dropped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued items at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        sample_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || taken) begin
            // free to offer a new item, or to idle
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending_items.pop_front();
                s_valid  <= 1'b1;
                s_sample <= it.sample;
                s_last   <= it.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls plus long hold-offs on request
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_tickets != hold_served) begin
            // start a hold-off; the sender keeps going so the job queue fills
            m_ready     <= 1'b0;
            hold_left   <= HOLD_LEN - 1;
            hold_served <= hold_served + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: samples both handshakes at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        run_result_t want;
        if (!aresetn) begin
            taken <= 1'b0;
        end else begin
            taken <= s_valid && s_ready;
            // result side first: it always belongs to an earlier run
            if (m_valid && m_ready) begin
                if (std_expected.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, %s %0d %s %0b",
                             $time, "actual std_dev", m_std_dev, "overflow", m_overflow);
                    error_count++;
                end else begin
                    want = std_expected.pop_front();
                    if (m_std_dev !== want.std_dev) begin
                        $display("%0t ns: std_dev expected %0d actual %0d",
                                 $time, want.std_dev, m_std_dev);
                        error_count++;
                    end
                    if (m_overflow !== want.overflow) begin
                        $display("%0t ns: overflow expected %0b actual %0b",
                                 $time, want.overflow, m_overflow);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                items_taken++;
                absorb_sample(s_sample, s_last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_sample(logic signed [psd_pkg::SAMPLE_W-1:0] sample, logic last);
        sample_item_t it;
        it.sample = sample;
        it.last   = last;
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic signed [psd_pkg::SAMPLE_W-1:0] pick_sample(
        run_style_t style, logic [psd_pkg::SAMPLE_W-1:0] base);
        unique case (style)
            RUN_EXTREMES: begin
                return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            end
            RUN_CONSTANT: begin
                return base;
            end
            RUN_CLUSTER: begin
                // narrow spread around a random center, wrapping at the ends
                return base + psd_pkg::SAMPLE_W'($urandom_range(15)) - psd_pkg::SAMPLE_W'(8);
            end
            default: begin
                return psd_pkg::SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    task automatic queue_run(int len, run_style_t style, logic [psd_pkg::SAMPLE_W-1:0] base);
        for (int i = 0; i < len; i++) begin
            queue_sample(pick_sample(style, base), i == len - 1);
        end
    endtask

    // random run length, mostly short so results come often
    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            return $urandom_range(3, 1);
        end else if (r < 85) begin
            return $urandom_range(24, 4);
        end
        return $urandom_range(120, 25);
    endfunction

    task automatic queue_random_runs(int budget);
        int         added;
        int         len;
        run_style_t style;
        added = 0;
        while (added < budget) begin
            len   = pick_length();
            style = run_style_t'($urandom_range(3));
            queue_run(len, style, psd_pkg::SAMPLE_W'($urandom));
            added += len;
        end
    endtask

    // hold the stimulus until every item is in and every result is out
    task automatic drain();
        while (items_taken != items_queued || std_expected.size() != 0) begin
            @(negedge aclk);
        end
        @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single items give zero deviation
        queue_sample(16'sh7fff, 1'b1);
        queue_sample(16'sh8000, 1'b1);
        queue_sample(16'sh0000, 1'b1);
        // both extremes: largest possible deviation
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7fff, 1'b1);
        // half-step deviation
        queue_sample(16'sh0000, 1'b0);
        queue_sample(16'sh0001, 1'b1);
        // constant runs at the extremes
        queue_run(3, RUN_CONSTANT, 16'h7fff);
        queue_run(3, RUN_CONSTANT, 16'h8000);
        // alternating extremes
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7fff, 1'b1);
        // mixed signs around zero
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd1, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sd100, 1'b1);
        drain();

        // random phases under each idling pattern
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_runs(PHASE_ITEMS);
        drain();

        send_idle_pct  = 73;
        recv_stall_pct = 0;
        queue_random_runs(PHASE_ITEMS);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 73;
        queue_random_runs(PHASE_ITEMS);
        drain();

        // receiver holds off while single-item runs keep coming, input stalls
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_tickets++;
        for (int i = 0; i < 40; i++) begin
            queue_sample(psd_pkg::SAMPLE_W'($urandom), 1'b1);
        end
        queue_random_runs(60);
        drain();

        send_idle_pct  = 24;
        recv_stall_pct = 24;
        queue_random_runs(PHASE_ITEMS);
        drain();

        // nothing more is owed; watch for stray results
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (std_expected.size() != 0) begin
            $display("%0t ns: %0d results expected but not received",
                     $time, std_expected.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/psd_pkg.sv
design/psd_front.sv
design/psd_fifo.sv
design/psd_back.sv
design/population_std_deviation.sv
tb/population_std_deviation_tb.sv
